### rtl/core/tclb_pkg.sv
package tclb_pkg;

  localparam int unsigned SCORE_W = 40;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned SIZE_W = 7;
  localparam int unsigned K_W = 7;
  // 40-bit nonnegative operand times a 7-bit percentage
  localparam int unsigned PROD_W = 47;
  localparam int unsigned DIV_CNT_W = 2;

  // x / 100 for x below 2**46 is (x * RECIP_100) >> RECIP_SHIFT, exact
  localparam int unsigned RECIP_W = 48;
  localparam int unsigned RECIP_SHIFT = 53;
  localparam int unsigned SLICE_W = 16;
  localparam int unsigned ACC_W = PROD_W + RECIP_W;

  typedef logic signed [SCORE_W-1:0] score_t;

  localparam logic [CFG_IDX_W-1:0] CFG_LIST_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIST_SIZE = 2'd1;

  localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIXED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RANGE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BELOW = 2'd3;

  localparam logic [MODE_W-1:0] MODE_RESET = MODE_FIXED;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd5;

  // 0.001 and 0.01 in Q23.16
  localparam score_t MIN_THR = 40'sd65;
  localparam score_t NEXT_FLOOR = 40'sd655;
  localparam score_t LO_INIT = {1'b0, {(SCORE_W - 1) {1'b1}}};

  localparam logic [K_W-1:0] RESULT_CAP = 7'd64;
  localparam logic [SIZE_W-1:0] PCT_FULL = 7'd100;
  localparam logic [RECIP_W-1:0] RECIP_100 = 48'd90071992547410;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(RECIP_W / SLICE_W - 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_MUL    = 6'b001000,
    S_DIV    = 6'b010000,
    S_FLUSH  = 6'b100000
  } state_e;

endpackage

### rtl/core/tclb_ram.sv
module tclb_ram #(
  parameter int unsigned WIDTH = 51,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/threshold_candidate_list_builder.sv
// Restricted candidate list builder. Candidates (client id, Q23.16 score) are taken one per
// cycle into a single-port-write, registered-read RAM of MAX_CANDIDATES entries, each entry
// also carrying its taken flag; candidates past a full store are dropped. The item with
// last_candidate set closes the batch of n stored candidates and the block then stalls its
// input until the final list entry sits in the output register. Every list entry costs one
// pass over the RAM (one read per cycle) and a decision step, and modes 2 and 3 add the
// threshold, a multiply by the percentage followed by a divide by 100 done as a three-step
// multiply by its reciprocal. The first entry is the best positive score (id 0, score 0 when
// none is positive); last_of_run marks the final entry. The user must write list_mode and
// list_size through the configuration port only while the block is idle; the block itself
// does not enforce it.
module threshold_candidate_list_builder #(
  parameter int unsigned MAX_CANDIDATES = 64,
  parameter int unsigned ID_WIDTH = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [tclb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tclb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ID_WIDTH-1:0]        client_id_i,
  input  tclb_pkg::score_t           score_i,
  input  logic                       last_candidate_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ID_WIDTH-1:0]        list_client_o,
  output tclb_pkg::score_t           list_score_o,
  output logic                       last_of_run_o
);

  import tclb_pkg::*;

  localparam int unsigned AW = $clog2(MAX_CANDIDATES);
  localparam int unsigned CW = $clog2(MAX_CANDIDATES + 1);
  localparam int unsigned WW = 1 + ID_WIDTH + SCORE_W;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_CANDIDATES);

  state_e state_q, state_d;

  logic [SIZE_W-1:0] list_size_q;
  logic [MODE_W-1:0] list_mode_q;
  logic [CW-1:0]     count_q, n_q, rd_idx_q;
  logic [K_W-1:0]    k_q;
  logic              first_q, vld_q, out_valid_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;

  // payload
  logic [AW-1:0]       cmp_idx_q, cur_idx_q;
  score_t              cur_q, lo_q, thr_q, base_q;
  logic [ID_WIDTH-1:0] cur_id_q, pend_id_q, out_id_q;
  score_t              pend_score_q, out_score_q;
  logic                found_q, out_last_q;
  logic [SCORE_W-1:0]  mul_a_q;
  logic [SIZE_W-1:0]   pct_q;
  logic [PROD_W-1:0]   div_q;
  logic [ACC_W-1:0]    acc_q;

  logic                in_acc, store_en, issue, scan_done, out_free;
  logic                start_scan, mark_taken, push_mid, push_last;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [WW-1:0]       wdata, rdata;
  logic                rd_taken;
  logic [ID_WIDTH-1:0] rd_id;
  score_t              rd_score;
  logic                better, lower;
  logic                hit, stop;
  logic [K_W-1:0]      k_inc;
  score_t              lo_eff;
  logic [SLICE_W-1:0]  recip_slice;
  logic [ACC_W-1:0]    acc_next;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign store_en  = in_acc && (count_q != MaxCnt);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign issue     = (state_q == S_SCAN) && (rd_idx_q != n_q);
  assign scan_done = (state_q == S_SCAN) && (rd_idx_q == n_q) && !vld_q;

  assign rd_taken = rdata[WW-1];
  assign rd_id    = rdata[SCORE_W +: ID_WIDTH];
  assign rd_score = rdata[SCORE_W-1:0];

  // strict compare keeps the earliest of equal scores
  assign better = vld_q && !rd_taken && (rd_score > cur_q);
  assign lower  = vld_q && first_q && (rd_score > 0) && (rd_score < lo_q);

  assign hit   = found_q && (cur_q > thr_q);
  assign k_inc = k_q + 1'b1;
  assign stop  = ((list_mode_q == MODE_FIXED) && (k_inc >= list_size_q)) ||
                 (k_inc >= RESULT_CAP);
  assign lo_eff = found_q ? lo_q : '0;

  // reciprocal slices, most significant first
  always_comb begin
    unique case (div_cnt_q)
      2'd0:    recip_slice = RECIP_100[RECIP_W-1 -: SLICE_W];
      2'd1:    recip_slice = RECIP_100[RECIP_W-SLICE_W-1 -: SLICE_W];
      default: recip_slice = RECIP_100[SLICE_W-1:0];
    endcase
  end

  assign acc_next = {acc_q[ACC_W-SLICE_W-1:0], {SLICE_W{1'b0}}} +
                    ACC_W'(div_q) * ACC_W'(recip_slice);

  assign mark_taken = (state_q == S_DECIDE) && found_q &&
                      (first_q || (hit && out_free));
  assign push_mid   = (state_q == S_DECIDE) && !first_q && hit && out_free;
  assign push_last  = (state_q == S_FLUSH) && out_free;

  assign we    = store_en || mark_taken;
  assign waddr = store_en ? count_q[AW-1:0] : cur_idx_q;
  assign wdata = store_en ? {1'b0, client_id_i, score_i} : {1'b1, cur_id_q, cur_q};

  tclb_ram #(
    .WIDTH(WW),
    .DEPTH(MAX_CANDIDATES)
  ) u_cand_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (issue),
    .raddr_i(rd_idx_q[AW-1:0]),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d = state_q;
    start_scan = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && last_candidate_i) begin
          state_d = S_SCAN;
          start_scan = 1'b1;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (first_q) begin
          if (list_mode_q == MODE_RANGE || list_mode_q == MODE_BELOW) begin
            state_d = S_MUL;
          end else begin
            state_d = S_SCAN;
            start_scan = 1'b1;
          end
        end else if (!hit) begin
          state_d = S_FLUSH;
        end else if (out_free) begin
          if (stop) begin
            state_d = S_FLUSH;
          end else begin
            state_d = S_SCAN;
            start_scan = 1'b1;
          end
        end
      end
      S_MUL: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_cnt_q == DIV_LAST) begin
          state_d = S_SCAN;
          start_scan = 1'b1;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      list_mode_q <= MODE_RESET;
      list_size_q <= SIZE_RESET;
      count_q     <= '0;
      n_q         <= '0;
      rd_idx_q    <= '0;
      k_q         <= '0;
      first_q     <= 1'b0;
      vld_q       <= 1'b0;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_LIST_MODE) begin
          list_mode_q <= cfg_data_i[MODE_W-1:0];
        end else if (cfg_index_i == CFG_LIST_SIZE) begin
          list_size_q <= cfg_data_i[SIZE_W-1:0];
        end
      end
      if (store_en) begin
        count_q <= count_q + 1'b1;
      end
      if (in_acc && last_candidate_i) begin
        n_q     <= store_en ? count_q + 1'b1 : count_q;
        first_q <= 1'b1;
        k_q     <= '0;
      end
      vld_q <= issue;
      if (start_scan) begin
        rd_idx_q <= '0;
      end else if (issue) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (state_q == S_DECIDE && first_q) begin
        first_q <= 1'b0;
        k_q     <= 7'd1;
      end
      if (push_mid) begin
        k_q <= k_inc;
      end
      if (state_q == S_MUL) begin
        div_cnt_q <= '0;
      end else if (state_q == S_DIV) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end
      if (push_mid || push_last) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (push_last) begin
        count_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= rd_idx_q[AW-1:0];
    if (start_scan) begin
      // only the first pass starts from zero, later passes start at the search floor
      cur_q   <= (state_q == S_IDLE) ? score_t'(0) : NEXT_FLOOR;
      found_q <= 1'b0;
      lo_q    <= LO_INIT;
    end else begin
      if (better) begin
        cur_q     <= rd_score;
        cur_id_q  <= rd_id;
        cur_idx_q <= cmp_idx_q;
        found_q   <= 1'b1;
      end
      if (lower) begin
        lo_q <= rd_score;
      end
    end
    if (state_q == S_DECIDE && first_q) begin
      pend_id_q    <= found_q ? cur_id_q : '0;
      pend_score_q <= cur_q;
      pct_q        <= (list_size_q > PCT_FULL) ? '0 : PCT_FULL - list_size_q;
      thr_q        <= MIN_THR;
      if (list_mode_q == MODE_RANGE) begin
        mul_a_q <= cur_q - lo_eff;
        base_q  <= lo_eff;
      end else begin
        mul_a_q <= cur_q;
        base_q  <= '0;
      end
    end
    // divide by 100 as a multiply by the reciprocal, one slice a cycle
    if (state_q == S_MUL) begin
      div_q <= mul_a_q * pct_q;
      acc_q <= '0;
    end else if (state_q == S_DIV) begin
      acc_q <= acc_next;
      if (div_cnt_q == DIV_LAST) begin
        thr_q <= base_q + score_t'(acc_next[RECIP_SHIFT +: SCORE_W]);
      end
    end
    if (push_mid) begin
      out_id_q     <= pend_id_q;
      out_score_q  <= pend_score_q;
      out_last_q   <= 1'b0;
      pend_id_q    <= cur_id_q;
      pend_score_q <= cur_q;
    end else if (push_last) begin
      out_id_q    <= pend_id_q;
      out_score_q <= pend_score_q;
      out_last_q  <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign list_client_o = out_id_q;
  assign list_score_o  = out_score_q;
  assign last_of_run_o = out_last_q;

endmodule

### tb/sv/candidate_list_checker.sv
module candidate_list_checker
  import tclb_pkg::*;
#(
  parameter int unsigned ID_W  = 10,
  parameter int unsigned DEPTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [ID_W-1:0]       client_id_i,
  input  score_t                score_i,
  input  logic                  last_candidate_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [ID_W-1:0]       list_client_i,
  input  score_t                list_score_i,
  input  logic                  last_of_run_i,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [ID_W-1:0] client;
    score_t          score;
    logic            last;
  } list_entry_t;

  list_entry_t       list_q[$];
  logic [ID_W-1:0]   cand_id[DEPTH];
  score_t            cand_score[DEPTH];
  bit                taken[DEPTH];
  int unsigned       batch_len;
  logic [MODE_W-1:0] mode_r;
  logic [SIZE_W-1:0] size_r;

  task automatic build_list();
    score_t      best, lo, nxt;
    longint      thr, pct;
    int unsigned best_idx, pick;
    int          k;
    bit          have_best, found;
    list_entry_t entry;
    list_entry_t run_q[$];
    best = '0;
    best_idx = 0;
    have_best = 1'b0;
    for (int unsigned i = 0; i < batch_len; i++) begin
      if (cand_score[i] > best) begin
        best = cand_score[i];
        best_idx = i;
        have_best = 1'b1;
      end
    end
    entry.client = have_best ? cand_id[best_idx] : '0;
    entry.score = best;
    entry.last = 1'b0;
    run_q.push_back(entry);
    if (have_best) taken[best_idx] = 1'b1;
    k = 1;

    // percentages above full scale saturate
    pct = (size_r > PCT_FULL) ? 0 : 100 - longint'(size_r);
    case (mode_r)
      MODE_RANGE: begin
        lo = best;
        for (int unsigned i = 0; i < batch_len; i++) begin
          if (cand_score[i] > 0 && cand_score[i] < lo) lo = cand_score[i];
        end
        thr = longint'(lo) + ((longint'(best) - longint'(lo)) * pct) / 100;
      end
      MODE_BELOW: thr = (longint'(best) * pct) / 100;
      default: thr = longint'(MIN_THR);
    endcase

    while (k < int'(RESULT_CAP)) begin
      nxt = NEXT_FLOOR;
      pick = 0;
      found = 1'b0;
      for (int unsigned i = 0; i < batch_len; i++) begin
        if (!taken[i] && cand_score[i] > nxt) begin
          nxt = cand_score[i];
          pick = i;
          found = 1'b1;
        end
      end
      if (!found || longint'(nxt) <= thr) break;
      taken[pick] = 1'b1;
      entry.client = cand_id[pick];
      entry.score = nxt;
      entry.last = 1'b0;
      run_q.push_back(entry);
      k++;
      // fixed length is only checked once a further entry went out
      if (mode_r == MODE_FIXED && k >= int'(size_r)) break;
    end

    run_q[run_q.size() - 1].last = 1'b1;
    foreach (run_q[j]) list_q.push_back(run_q[j]);
    batch_len = 0;
    foreach (taken[j]) taken[j] = 1'b0;
  endtask

  task automatic take_candidate();
    // a full store drops the item, a closing flag still counts
    if (batch_len < DEPTH) begin
      cand_id[batch_len] = client_id_i;
      cand_score[batch_len] = score_i;
      taken[batch_len] = 1'b0;
      batch_len++;
    end
    if (last_candidate_i) build_list();
  endtask

  task automatic check_entry();
    list_entry_t want;
    if (list_q.size() == 0) begin
      $error("unexpected list item: list_client %0d list_score %0d last_of_run %0b",
             list_client_i, list_score_i, last_of_run_i);
      fail_count_o++;
      return;
    end
    want = list_q.pop_front();
    if (list_client_i !== want.client) begin
      $error("list_client: expected %0d, actual %0d", want.client, list_client_i);
      fail_count_o++;
    end
    if (list_score_i !== want.score) begin
      $error("list_score: expected %0d, actual %0d", want.score, list_score_i);
      fail_count_o++;
    end
    if (last_of_run_i !== want.last) begin
      $error("last_of_run: expected %0b, actual %0b", want.last, last_of_run_i);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_r = MODE_RESET;
      size_r = SIZE_RESET;
      batch_len = 0;
      list_q.delete();
      foreach (taken[j]) taken[j] = 1'b0;
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_LIST_MODE: mode_r = cfg_data_i[MODE_W-1:0];
          CFG_LIST_SIZE: mode_r = mode_r;
          default: ;
        endcase
        if (cfg_index_i == CFG_LIST_SIZE) size_r = cfg_data_i[SIZE_W-1:0];
      end
      if (out_valid_i && !out_stall_i) check_entry();
      if (in_valid_i && !in_stall_i) take_candidate();
      pending_o = list_q.size();
    end
  end

endmodule

### tb/sv/tb_threshold_candidate_list_builder.sv
module tb_threshold_candidate_list_builder;
  timeunit 1ns;
  timeprecision 1ps;
  import tclb_pkg::*;

  localparam int ID_W = 10;
  localparam int STORE_DEPTH = 64;
  localparam int SETTLE_CYCLES = 160;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TARGET_ITEMS = 160;
  localparam score_t SCORE_MAX = {1'b0, {(SCORE_W - 1) {1'b1}}};
  localparam score_t SCORE_MIN = {1'b1, {(SCORE_W - 1) {1'b0}}};

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_LIST_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ID_W-1:0]       client_id = '0;
  score_t                score = '0;
  logic                  last_cand = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ID_W-1:0]       list_client;
  score_t                list_score;
  logic                  last_of_run;
  int                    fail_count;
  int                    pending;

  int                    cycle_count = 0;
  int                    stall_kind = 0;
  int                    stall_run = 0;
  int                    items_sent = 0;
  int                    burst_left = 0;
  bit                    gaps_on = 1'b1;
  logic [ID_W-1:0]       prev_id = '0;
  score_t                prev_score = '0;

  threshold_candidate_list_builder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .client_id_i     (client_id),
    .score_i         (score),
    .last_candidate_i(last_cand),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .list_client_o   (list_client),
    .list_score_o    (list_score),
    .last_of_run_o   (last_of_run)
  );

  candidate_list_checker #(
    .ID_W (ID_W),
    .DEPTH(STORE_DEPTH)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .client_id_i     (client_id),
    .score_i         (score),
    .last_candidate_i(last_cand),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .list_client_i   (list_client),
    .list_score_i    (list_score),
    .last_of_run_i   (last_of_run),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver stall pattern, switching between quiet, light, heavy and periodic
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (stall_run == 0) begin
      stall_kind = $urandom_range(0, 3);
      stall_run = $urandom_range(20, 200);
    end else begin
      stall_run--;
    end
    case (stall_kind)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= cycle_count[2];
    endcase
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL threshold_candidate_list_builder");
      $finish;
    end
  end

  task automatic send_candidate(input logic [ID_W-1:0] id, input score_t sc, input logic last);
    in_valid <= 1'b1;
    client_id <= id;
    score <= sc;
    last_cand <= last;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 8);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  // hold the sender until every list entry is out, then let the block settle
  task automatic wait_list_done();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [MODE_W-1:0] mode, input logic [SIZE_W-1:0] size);
    wait_list_done();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_LIST_MODE;
    // upper data bits are don't-care for the mode register
    cfg_data <= {(CFG_DATA_W - MODE_W)'($urandom), mode};
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= CFG_LIST_SIZE;
    cfg_data <= size;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure_random();
    logic [MODE_W-1:0] mode;
    logic [SIZE_W-1:0] size;
    mode = MODE_W'($urandom_range(MODE_PLAIN, MODE_BELOW));
    case ($urandom_range(0, 5))
      0: size = '0;
      1: size = PCT_FULL;
      2: size = SIZE_W'($urandom_range(101, 127));
      3: size = SIZE_W'($urandom_range(1, 5));
      default: size = SIZE_W'($urandom_range(0, 100));
    endcase
    configure(mode, size);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    logic [ID_W-1:0] id;
    case ($urandom_range(0, 9))
      0: id = '0;
      1: id = '1;
      2: id = prev_id;
      default: id = ID_W'($urandom_range(1, 1023));
    endcase
    prev_id = id;
    return id;
  endfunction

  function automatic score_t pick_score(input bit favor_high);
    score_t s;
    if (favor_high && $urandom_range(0, 3) != 0) begin
      s = score_t'($urandom_range(656, 2000000));
    end else begin
      case ($urandom_range(0, 9))
        0, 1: s = score_t'($urandom_range(0, 1400));
        2: s = -score_t'($urandom_range(1, 1000000));
        3, 4: s = score_t'({$urandom, $urandom});
        5: s = prev_score;
        6: s = $urandom_range(0, 1) ? SCORE_MAX : SCORE_MIN;
        default: s = score_t'({7'($urandom), $urandom});
      endcase
    end
    prev_score = s;
    return s;
  endfunction

  initial begin
    int len;
    int batches;
    batches = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: fixed length of five, floor edges and score extremes
    send_candidate(10'd1023, SCORE_MAX, 1'b0);
    send_candidate(10'd1, SCORE_MIN, 1'b0);
    send_candidate(10'd0, 40'sd656, 1'b0);
    send_candidate(10'd512, 40'sd655, 1'b1);
    // nothing positive
    send_candidate(10'd7, -40'sd1, 1'b1);

    // ties keep the earliest, duplicate ids, plain-threshold edge
    configure(MODE_PLAIN, 7'd0);
    send_candidate(10'd10, 40'sd65, 1'b0);
    send_candidate(10'd11, 40'sd66, 1'b0);
    send_candidate(10'd12, 40'sd700, 1'b0);
    send_candidate(10'd12, 40'sd700, 1'b0);
    send_candidate(10'd14, 40'sd700, 1'b0);
    send_candidate(10'd15, 40'sd0, 1'b1);

    // size zero in fixed mode still lets a second entry out
    configure(MODE_FIXED, 7'd0);
    send_candidate(10'd1, 40'sd5000, 1'b0);
    send_candidate(10'd2, 40'sd4000, 1'b0);
    send_candidate(10'd3, 40'sd3000, 1'b1);

    configure(MODE_RANGE, 7'd50);
    send_candidate(10'd100, 40'sd1000, 1'b0);
    send_candidate(10'd101, 40'sd3000, 1'b0);
    send_candidate(10'd102, 40'sd2000, 1'b0);
    send_candidate(10'd103, 40'sd100, 1'b1);

    // percentage above full scale
    configure(MODE_BELOW, 7'd127);
    send_candidate(10'd5, SCORE_MAX, 1'b0);
    send_candidate(10'd6, SCORE_MAX - 40'sd1, 1'b0);
    send_candidate(10'd1023, 40'sd700, 1'b1);

    configure(MODE_BELOW, 7'd0);
    send_candidate(10'd9, 40'sd800, 1'b0);
    send_candidate(10'd8, 40'sd800, 1'b1);

    while (items_sent < TARGET_ITEMS || batches < 4) begin
      if (batches == 3) begin
        configure(MODE_PLAIN, SIZE_W'($urandom_range(0, 100)));
      end else if ($urandom_range(0, 2) == 0) begin
        configure_random();
      end else if ($urandom_range(0, 7) == 0) begin
        wait_list_done();
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      if (batches == 3) begin
        // overfills the store so trailing items are dropped
        len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 6);
      end else begin
        len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12);
      end
      for (int j = 0; j < len; j++) begin
        send_candidate(pick_id(), pick_score(len > STORE_DEPTH), (j == len - 1));
      end
      batches++;
    end

    wait_list_done();
    if (fail_count == 0 && pending == 0) begin
      $display("PASS threshold_candidate_list_builder");
    end else begin
      $display("FAIL threshold_candidate_list_builder");
    end
    $finish;
  end

endmodule
